[hdl/pcd_pkg.sv]
// Shared types and constants of the prefixed checksum deframer.
package pcd_pkg;

	// Field widths.
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned CNT_W = 8;
	localparam int unsigned LEN_W = 4;
	localparam int unsigned CODE_W = 64;
	localparam int unsigned APB_DATA_W = 64;
	localparam int unsigned APB_ADDR_W = 4;

	// Default largest security code length in bytes.
	localparam int unsigned MAX_CODE_BYTES_DEF = 8;

	// Register indexes, taken from paddr bit 3.
	localparam logic REG_CODE_LENGTH = 1'b0;
	localparam logic REG_CODE_BYTES = 1'b1;

	// Result kinds.
	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	typedef enum logic [1:0] {
		VERD_OK    = 2'd0,
		VERD_CODE  = 2'd1,
		VERD_SUM   = 2'd2,
		VERD_SHORT = 2'd3
	} verdict_t;

	// One result item.
	typedef struct packed {
		logic              kind;
		logic [BYTE_W-1:0] payload;
		verdict_t          verdict;
		logic [CNT_W-1:0]  count;
		logic              last;
	} res_t;

	// Results produced by one accepted request: num of them, r0 first.
	typedef struct packed {
		logic [1:0] num;
		res_t       r0;
		res_t       r1;
	} push_t;

	// Configuration register contents.
	typedef struct packed {
		logic [LEN_W-1:0]  code_length;
		logic [CODE_W-1:0] code_bytes;
	} cfg_t;

endpackage

[hdl/prefixed_checksum_deframer.sv]
// Top level of the prefixed checksum deframer.
// Checks each received burst for a leading security code of up to
// MAX_CODE_BYTES bytes, forwards the bytes after it as payload (one request
// late, since the final byte is the checksum) and ends every burst with a
// verdict result carrying the payload count. One input request is accepted
// per clock cycle: the checking logic works in a single pass from the burst
// state registers into a four-entry result queue. A final byte that releases
// a held payload byte yields two results, the payload and then the verdict;
// s_tready stays high while the queue holds two results or fewer, so the
// input stalls only when the output side falls behind. Configure only while
// no burst is in flight.
module prefixed_checksum_deframer
	import pcd_pkg::*;
#(
	parameter int unsigned MAX_CODE_BYTES = MAX_CODE_BYTES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,  // [7:0] rx_byte
	input  logic                  s_tlast,  // burst_end
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// [7:0] payload_byte, [9:8] verdict, [17:10] payload_count, [23:18] zero
	output logic [23:0]           m_tdata,
	output logic                  m_tuser,  // result_kind
	output logic                  m_tlast   // run_last
);

	cfg_t  cfg;
	push_t push;
	res_t  head;
	logic  room;
	logic  in_valid;

	assign s_tready = room;
	assign in_valid = s_tvalid & s_tready;

	pcd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pcd_core #(
		.MAX_CODE_BYTES (MAX_CODE_BYTES)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (in_valid),
		.rx_byte   (s_tdata),
		.burst_end (s_tlast),
		.push      (push)
	);

	pcd_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (head)
	);

	// Pack the head result onto the master side.
	assign m_tdata = {6'b000000, head.count, head.verdict, head.payload};
	assign m_tuser = head.kind;
	assign m_tlast = head.last;

endmodule

[hdl/pcd_regs.sv]
// APB configuration registers of the prefixed checksum deframer.
module pcd_regs
	import pcd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	logic [LEN_W-1:0]  code_length_q;
	logic [CODE_W-1:0] code_bytes_q;
	logic              wr_en;

	assign pready = 1'b1;
	assign wr_en = psel & penable & pwrite & pready;

	// Register writes; registers sit at byte addresses 0 and 8.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_length_q <= '0;
			code_bytes_q <= '0;
		end else if (wr_en) begin
			if (paddr[3] == REG_CODE_LENGTH) begin
				code_length_q <= pwdata[LEN_W-1:0];
			end else begin
				code_bytes_q <= pwdata[CODE_W-1:0];
			end
		end
	end

	// Read back.
	always_comb begin
		if (paddr[3] == REG_CODE_LENGTH) begin
			prdata = {{(APB_DATA_W-LEN_W){1'b0}}, code_length_q};
		end else begin
			prdata = code_bytes_q;
		end
	end

	assign cfg.code_length = code_length_q;
	assign cfg.code_bytes = code_bytes_q;

endmodule

[hdl/pcd_core.sv]
// Burst state and per-byte checking logic of the prefixed checksum deframer.
module pcd_core
	import pcd_pkg::*;
#(
	parameter int unsigned MAX_CODE_BYTES = MAX_CODE_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              in_valid,
	input  logic [BYTE_W-1:0] rx_byte,
	input  logic              burst_end,
	output push_t             push
);

	localparam int unsigned POS_W = $clog2(MAX_CODE_BYTES + 1);

	logic [POS_W-1:0]  pos_q, pos_n;
	logic [BYTE_W-1:0] sum_q, sum_n;
	logic              failed_q, failed_n;
	logic [BYTE_W-1:0] held_q, held_n;
	logic              held_valid_q, held_valid_n;
	logic [CNT_W-1:0]  seen_q, seen_n;

	logic [POS_W-1:0]  eff_len;
	logic [2:0]        code_sel;
	logic [BYTE_W-1:0] want;
	logic              mismatch;
	res_t              pay_res;
	res_t              ver_res;

	// Effective code length: lengths above the maximum count as the maximum.
	assign eff_len = (cfg.code_length > LEN_W'(MAX_CODE_BYTES)) ?
		POS_W'(MAX_CODE_BYTES) : POS_W'(cfg.code_length);

	// Expected code byte at the current position.
	assign code_sel = 3'(pos_q);
	assign want = cfg.code_bytes[8*code_sel +: 8];
	assign mismatch = (rx_byte != want);

	// Next burst state and results of the request.
	always_comb begin
		pos_n = pos_q;
		sum_n = sum_q;
		failed_n = failed_q;
		held_n = held_q;
		held_valid_n = held_valid_q;
		seen_n = seen_q;
		push.num = 2'd0;

		pay_res.kind = KIND_PAYLOAD;
		pay_res.payload = held_q;
		pay_res.verdict = VERD_OK;
		pay_res.count = '0;
		pay_res.last = ~burst_end;

		ver_res.kind = KIND_VERDICT;
		ver_res.payload = '0;
		ver_res.verdict = VERD_OK;
		ver_res.count = '0;
		ver_res.last = 1'b1;

		push.r0 = ver_res;
		push.r1 = ver_res;

		if (pos_q < eff_len) begin
			// Code byte: compare against the security code.
			failed_n = failed_q | mismatch;
			sum_n = sum_q + rx_byte;
			pos_n = pos_q + POS_W'(1);
			if (burst_end) begin
				ver_res.verdict = (failed_q | mismatch) ? VERD_CODE : VERD_SHORT;
				push.r0 = ver_res;
				push.num = 2'd1;
			end
		end else if (failed_q) begin
			// Failed burst: swallow bytes until the end.
			if (burst_end) begin
				ver_res.verdict = VERD_CODE;
				push.r0 = ver_res;
				push.num = 2'd1;
			end
		end else begin
			// Past the code: release the held byte, then hold or judge this one.
			if (held_valid_q) begin
				sum_n = sum_q + held_q;
				seen_n = (seen_q == '1) ? seen_q : seen_q + CNT_W'(1);
			end
			if (burst_end) begin
				ver_res.verdict = (rx_byte == sum_n) ? VERD_OK : VERD_SUM;
				ver_res.count = seen_n;
			end
			if (held_valid_q) begin
				push.r0 = pay_res;
				push.r1 = ver_res;
				push.num = burst_end ? 2'd2 : 2'd1;
			end else begin
				push.r0 = ver_res;
				push.num = burst_end ? 2'd1 : 2'd0;
			end
			held_n = rx_byte;
			held_valid_n = 1'b1;
		end

		// The final byte returns all burst state to zero.
		if (burst_end) begin
			pos_n = '0;
			sum_n = '0;
			failed_n = 1'b0;
			held_n = '0;
			held_valid_n = 1'b0;
			seen_n = '0;
		end

		if (!in_valid) begin
			push.num = 2'd0;
		end
	end

	// Burst state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			sum_q <= '0;
			failed_q <= 1'b0;
			held_q <= '0;
			held_valid_q <= 1'b0;
			seen_q <= '0;
		end else if (in_valid) begin
			pos_q <= pos_n;
			sum_q <= sum_n;
			failed_q <= failed_n;
			held_q <= held_n;
			held_valid_q <= held_valid_n;
			seen_q <= seen_n;
		end
	end

endmodule

[hdl/pcd_outq.sv]
// Four-entry result queue; takes up to two results, gives one per ready cycle.
module pcd_outq
	import pcd_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  push_t push,
	output logic  room,
	output logic  out_valid,
	input  logic  out_ready,
	output res_t  out_res
);

	res_t       mem_q [4];
	logic [1:0] wptr_q;
	logic [1:0] rptr_q;
	logic [2:0] count_q;
	logic       pop;

	assign out_valid = (count_q != 3'd0);
	assign pop = out_valid & out_ready;
	assign out_res = mem_q[rptr_q];

	// Two free entries are needed before a request is taken.
	assign room = (count_q <= 3'd2);

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push.num != 2'd0) begin
			mem_q[wptr_q] <= push.r0;
		end
		if (push.num == 2'd2) begin
			mem_q[wptr_q + 2'd1] <= push.r1;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			count_q <= '0;
		end else begin
			wptr_q <= wptr_q + push.num;
			if (pop) begin
				rptr_q <= rptr_q + 2'd1;
			end
			count_q <= count_q + {1'b0, push.num} - {2'b00, pop};
		end
	end

endmodule

[hdl/pcd_checker.sv]
// Port-level assertions of the prefixed checksum deframer and their bind.
module pcd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic        m_tuser,
	input logic        m_tlast
);

	// A stalled result holds its contents.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("stalled result changed");

	// A verdict always closes the results of its request and carries no byte.
	a_verdict_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast && (m_tdata[7:0] == 8'd0))
		else $error("verdict result malformed");

	// A payload result carries no verdict and no count.
	a_payload_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> (m_tdata[23:8] == 16'd0))
		else $error("payload result carries verdict fields");

	// Code mismatch and too short verdicts report a zero count.
	a_fail_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser && ((m_tdata[9:8] == 2'd1) || (m_tdata[9:8] == 2'd3))
			|-> (m_tdata[23:10] == 14'd0))
		else $error("failed burst reports payload count");

endmodule

bind prefixed_checksum_deframer pcd_checker u_pcd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

[tb/sv/tb_top.sv]
// Self-checking testbench of the prefixed checksum deframer.
module tb_top;
	import pcd_pkg::*;

	localparam int unsigned WATCHDOG_CYCLES = 1000;
	localparam int unsigned HOLD_OFF_CYCLES = 80;
	localparam int unsigned PHASE_REQUESTS = 160;
	localparam int unsigned NUM_PHASES = 7;

	typedef enum int {
		SHAPE_GOOD,
		SHAPE_BAD_SUM,
		SHAPE_BAD_CODE,
		SHAPE_SHORT,
		SHAPE_NOISE
	} burst_shape_t;

	// Predicts the deframer results and checks them in order.
	class deframe_scoreboard;
		logic [LEN_W-1:0]  code_len;
		logic [CODE_W-1:0] code;
		logic [3:0]        pos;
		logic [7:0]        sum;
		logic              failed;
		logic [7:0]        held;
		logic              held_ok;
		logic [7:0]        seen;
		res_t              expq[$];
		int unsigned       errors;
		int unsigned       payloads;
		int unsigned       verdicts[4];

		function new();
			code_len = '0;
			code = '0;
			errors = 0;
			payloads = 0;
			foreach (verdicts[i]) verdicts[i] = 0;
			clear();
		endfunction

		function void clear();
			pos = '0;
			sum = '0;
			failed = 1'b0;
			held = '0;
			held_ok = 1'b0;
			seen = '0;
		endfunction

		function void write_reg(logic idx, logic [63:0] value);
			if (idx == REG_CODE_LENGTH) begin
				code_len = value[LEN_W-1:0];
			end else begin
				code = value;
			end
		endfunction

		function void push(logic kind, logic [7:0] pb, verdict_t v, logic [7:0] cnt,
				logic last);
			res_t r;
			r.kind = kind;
			r.payload = pb;
			r.verdict = v;
			r.count = cnt;
			r.last = last;
			expq.push_back(r);
		endfunction

		// Works out the results of one accepted input byte.
		function void note_request(logic [7:0] b, logic fin);
			int unsigned lim;
			logic [7:0]  want;
			lim = (code_len > MAX_CODE_BYTES_DEF) ? MAX_CODE_BYTES_DEF : code_len;
			// Still inside the security code.
			if (pos < lim) begin
				want = 8'(code >> (8 * pos[2:0]));
				if (b != want) failed = 1'b1;
				sum = sum + b;
				pos = pos + 1'b1;
				if (fin) begin
					push(KIND_VERDICT, 8'd0, failed ? VERD_CODE : VERD_SHORT, 8'd0, 1'b1);
					clear();
				end
				return;
			end
			// A failed code swallows the rest of the burst.
			if (failed) begin
				if (fin) begin
					push(KIND_VERDICT, 8'd0, VERD_CODE, 8'd0, 1'b1);
					clear();
				end
				return;
			end
			// The byte held back so far turns out to be payload.
			if (held_ok) begin
				sum = sum + held;
				if (seen != 8'hFF) seen = seen + 1'b1;
				push(KIND_PAYLOAD, held, VERD_OK, 8'd0, !fin);
				held_ok = 1'b0;
			end
			if (fin) begin
				push(KIND_VERDICT, 8'd0, (b == sum) ? VERD_OK : VERD_SUM, seen, 1'b1);
				clear();
			end else begin
				held = b;
				held_ok = 1'b1;
			end
		endfunction

		function void cmp_field(string name, logic [7:0] e, logic [7:0] a);
			if (a !== e) begin
				$error("%s mismatch: expected %0d, actual %0d", name, e, a);
				errors++;
			end
		endfunction

		// Compares one delivered result with the oldest prediction.
		function void check_result(res_t got);
			res_t e;
			if (expq.size() == 0) begin
				$error("result with nothing expected: kind %0d payload %0d verdict %0d",
					got.kind, got.payload, got.verdict);
				errors++;
				return;
			end
			e = expq.pop_front();
			cmp_field("result_kind", e.kind, got.kind);
			cmp_field("payload_byte", e.payload, got.payload);
			cmp_field("verdict", e.verdict, got.verdict);
			cmp_field("payload_count", e.count, got.count);
			cmp_field("run_last", e.last, got.last);
			if (e.kind == KIND_VERDICT) begin
				verdicts[e.verdict]++;
			end else begin
				payloads++;
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [7:0]            s_tdata;   // [7:0] rx_byte
	logic                  s_tlast;   // burst_end
	logic                  m_tvalid;
	logic                  m_tready;
	logic [23:0]           m_tdata;   // [7:0] payload, [9:8] verdict, [17:10] count
	logic                  m_tuser;   // result_kind
	logic                  m_tlast;   // run_last

	deframe_scoreboard sb;
	logic [LEN_W-1:0]  cur_len;
	logic [CODE_W-1:0] cur_code;
	bit                idle_on;
	bit                hold_off_req;
	int unsigned       hold_cnt;
	int unsigned       sent_bytes;
	int unsigned       sent_bursts;
	int unsigned       quiet_cycles;
	res_t              got;

	prefixed_checksum_deframer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// Clock.
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Receiver side: random stall bursts, plus one long hold-off on request.
	initial begin
		m_tready = 1'b0;
		hold_cnt = 0;
		forever begin
			@(negedge clk);
			if (hold_cnt > 0) begin
				m_tready = 1'b0;
				hold_cnt--;
			end else if (hold_off_req) begin
				hold_off_req = 1'b0;
				hold_cnt = HOLD_OFF_CYCLES - 1;
				m_tready = 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				hold_cnt = $urandom_range(1, 5) - 1;
				m_tready = 1'b0;
			end else begin
				m_tready = 1'b1;
			end
		end
	end

	// Monitor: register writes, accepted requests and results, and the watchdog.
	always @(posedge clk) begin
		if (arst_n) begin
			if (psel && penable && pwrite && pready) sb.write_reg(paddr[3], pwdata);
			if (s_tvalid && s_tready) sb.note_request(s_tdata, s_tlast);
			if (m_tvalid && m_tready) begin
				got.kind = m_tuser;
				got.payload = m_tdata[7:0];
				got.verdict = verdict_t'(m_tdata[9:8]);
				got.count = m_tdata[17:10];
				got.last = m_tlast;
				sb.check_result(got);
			end
			if ((psel && penable && pwrite && pready) || (s_tvalid && s_tready) ||
					(m_tvalid && m_tready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= WATCHDOG_CYCLES) begin
				$display("Timeout: %0d cycles without any transfer", quiet_cycles);
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	function automatic logic [7:0] rand_byte();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic int unsigned code_span();
		return (cur_len > MAX_CODE_BYTES_DEF) ? MAX_CODE_BYTES_DEF : cur_len;
	endfunction

	// Register write with setup and access phases; called at a falling edge, returns at one.
	task automatic cfg_write(logic idx, logic [63:0] value);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 3'b000};
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		if (idx == REG_CODE_LENGTH) begin
			cur_len = value[LEN_W-1:0];
		end else begin
			cur_code = value;
		end
	endtask

	// Writes both registers; the length carries random upper bits.
	task automatic configure(logic [LEN_W-1:0] len, logic [63:0] code);
		logic [63:0] v;
		v = {$urandom, $urandom};
		v[LEN_W-1:0] = len;
		cfg_write(REG_CODE_LENGTH, v);
		cfg_write(REG_CODE_BYTES, code);
	endtask

	// Offers one byte, with an optional gap first, until it is taken.
	task automatic send_byte(logic [7:0] b, logic fin);
		if (idle_on && $urandom_range(0, 7) == 0) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = b;
		s_tlast = fin;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sent_bytes++;
		@(negedge clk);
	endtask

	// Builds one burst of the given shape and sends it.
	task automatic send_burst(burst_shape_t shape, int unsigned npay);
		logic [7:0]  q[$];
		logic [7:0]  sum;
		int unsigned lim;
		int unsigned k;
		lim = code_span();
		if (lim == 0 && shape == SHAPE_BAD_CODE) shape = SHAPE_BAD_SUM;
		if (lim == 0 && shape == SHAPE_SHORT) shape = SHAPE_GOOD;
		if (shape == SHAPE_NOISE) begin
			repeat ($urandom_range(1, 12)) q.push_back(rand_byte());
		end else begin
			for (k = 0; k < lim; k++) q.push_back(8'(cur_code >> (8 * k)));
			if (shape == SHAPE_BAD_CODE) begin
				k = $urandom_range(0, lim - 1);
				q[k] = q[k] ^ 8'($urandom_range(1, 255));
			end
			if (shape == SHAPE_SHORT) begin
				// Burst ends inside the code, sometimes with a wrong code byte too.
				k = $urandom_range(1, lim);
				while (q.size() > k) void'(q.pop_back());
				if ($urandom_range(0, 2) == 0) begin
					k = $urandom_range(0, q.size() - 1);
					q[k] = q[k] ^ 8'($urandom_range(1, 255));
				end
			end else begin
				repeat (npay) q.push_back(rand_byte());
				sum = '0;
				foreach (q[i]) sum = sum + q[i];
				if (shape == SHAPE_BAD_SUM) sum = sum ^ 8'($urandom_range(1, 255));
				q.push_back(sum);
			end
		end
		foreach (q[i]) send_byte(q[i], i == q.size() - 1);
		sent_bursts++;
	endtask

	// Stops offering and waits until every predicted result has come out.
	task automatic wait_idle();
		s_tvalid = 1'b0;
		while (sb.expq.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic random_burst();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			send_burst(SHAPE_GOOD, $urandom_range(0, 12));
		end else if (r < 72) begin
			send_burst(SHAPE_BAD_SUM, $urandom_range(0, 12));
		end else if (r < 84) begin
			send_burst(SHAPE_BAD_CODE, $urandom_range(0, 12));
		end else if (r < 92) begin
			send_burst(SHAPE_SHORT, 0);
		end else begin
			send_burst(SHAPE_NOISE, 0);
		end
	endtask

	// Main sequence.
	initial begin
		int unsigned target;
		logic [LEN_W-1:0] len;
		logic [63:0] code;
		sb = new();
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		cur_len = '0;
		cur_code = '0;
		idle_on = 1'b1;
		hold_off_req = 1'b0;
		sent_bytes = 0;
		sent_bursts = 0;
		quiet_cycles = 0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed bursts: normal, empty payload, bad checksum, bad code, too short.
		configure(4'd3, {$urandom, $urandom});
		send_burst(SHAPE_GOOD, 2);
		send_burst(SHAPE_GOOD, 0);
		send_burst(SHAPE_BAD_SUM, 1);
		send_burst(SHAPE_BAD_CODE, 1);
		send_burst(SHAPE_SHORT, 0);
		wait_idle();
		// No code at all: the checksum alone forms a burst.
		configure(4'd0, 64'd0);
		send_burst(SHAPE_GOOD, 0);
		send_burst(SHAPE_BAD_SUM, 0);
		wait_idle();

		// Random phases, each under its own register setting.
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				0: begin len = 4'd8; code = '1; end
				1: begin len = 4'd15; code = {$urandom, $urandom}; end
				2: begin len = 4'd2; code = '0; end
				3: begin len = 4'd0; code = {$urandom, $urandom}; end
				4: begin len = 4'd5; code = {$urandom, $urandom}; end
				5: begin len = 4'($urandom_range(0, 15)); code = {$urandom, $urandom}; end
				default: begin len = 4'd1; code = {$urandom, $urandom}; end
			endcase
			configure(len, code);
			idle_on = (ph != NUM_PHASES - 1);
			target = sent_bytes + PHASE_REQUESTS;
			if (ph == 1) begin
				// Receiver holds off while a long burst keeps coming.
				hold_off_req = 1'b1;
				send_burst(SHAPE_GOOD, 20);
			end
			if (ph == 2) begin
				// Enough payload to saturate the count.
				send_burst(SHAPE_GOOD, 260);
				target = sent_bytes + PHASE_REQUESTS / 2;
			end
			while (sent_bytes < target) random_burst();
			wait_idle();
		end

		repeat (8) @(negedge clk);
		$display("Sent %0d bytes in %0d bursts; checked %0d payload results.",
			sent_bytes, sent_bursts, sb.payloads);
		$display("Verdicts: ok %0d, code mismatch %0d, checksum mismatch %0d, too short %0d.",
			sb.verdicts[VERD_OK], sb.verdicts[VERD_CODE], sb.verdicts[VERD_SUM],
			sb.verdicts[VERD_SHORT]);
		if (sb.errors == 0 && sb.expq.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
